### sv/countdown_timer_seven_segment_top_assert.svh
// Assertion macros used by the checker file of the countdown timer.
`ifndef COUNTDOWN_TIMER_SEVEN_SEGMENT_TOP_ASSERT_SVH
`define COUNTDOWN_TIMER_SEVEN_SEGMENT_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define CDT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("countdown timer check failed");

// Next-cycle implication, quiet while reset is high.
`define CDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("countdown timer check failed");

`endif

### sv/cdt_pkg.sv
`default_nettype none

package cdt_pkg;

  // Operation codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_FORCE = 3'd4;

  // Button codes for the force operation
  localparam logic [1:0] BTN_HUNDREDTHS = 2'd1;
  localparam logic [1:0] BTN_SECONDS    = 2'd2;
  localparam logic [1:0] BTN_MINUTES    = 2'd3;

  // Field limits
  localparam logic [5:0] MAX_MINUTES    = 6'd59;
  localparam logic [5:0] MAX_SECONDS    = 6'd59;
  localparam logic [6:0] MAX_HUNDREDTHS = 7'd99;

  // Segment codes (gfedcba) for digits zero to nine
  localparam logic [6:0] SEG_CODE [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
  };

  typedef struct packed {
    logic [1:0] button;
    logic [6:0] load_hundredths;
    logic [6:0] load_seconds;
    logic [6:0] load_minutes;
    logic [2:0] operation;
  } req_t;

  typedef struct packed {
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] hundredths;
  } time_t;

  // Tens digit of a value below 128 by reciprocal multiply (x * 205 >> 11)
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  // Ones digit: value minus ten times the tens digit
  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t10;
    logic [6:0] d;
    t10 = 7'(tens_of(v)) * 7'd10;
    d   = v - t10;
    return d[3:0];
  endfunction

  // Segment byte of a digit; digits above nine wrap by ten
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [3:0] idx;
    idx = (digit > 4'd9) ? (digit - 4'd10) : digit;
    return {1'b0, SEG_CODE[idx]};
  endfunction

endpackage

`default_nettype wire

### sv/cdt_core.sv
`default_nettype none

module cdt_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire cdt_pkg::req_t req,
  output cdt_pkg::time_t     time_next,
  output logic               run_next
);

  cdt_pkg::time_t count;
  logic           run;

  // Hold the time and running flag; advance on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      count.minutes    <= cdt_pkg::MAX_MINUTES;
      count.seconds    <= cdt_pkg::MAX_SECONDS;
      count.hundredths <= cdt_pkg::MAX_HUNDREDTHS;
      run              <= 1'b1;
    end else if (en) begin
      count <= time_next;
      run   <= run_next;
    end
  end

  // Apply one operation to the current state
  always_comb begin
    time_next = count;
    run_next  = run;
    unique case (req.operation)
      cdt_pkg::OP_TICK: begin
        if (run) begin
          if (count == '0) begin
            run_next = 1'b0;
          end else begin
            // borrow chain: hundredths, then seconds, then minutes
            if (count.hundredths != '0) begin
              time_next.hundredths = count.hundredths - 7'd1;
            end else begin
              time_next.hundredths = cdt_pkg::MAX_HUNDREDTHS;
              if (count.seconds != '0) begin
                time_next.seconds = count.seconds - 6'd1;
              end else begin
                time_next.seconds = cdt_pkg::MAX_SECONDS;
                time_next.minutes = count.minutes - 6'd1;
              end
            end
            if (time_next == '0) begin
              run_next = 1'b0;
            end
          end
        end
      end
      cdt_pkg::OP_LOAD: begin
        time_next.minutes = (req.load_minutes > {1'b0, cdt_pkg::MAX_MINUTES}) ?
                            cdt_pkg::MAX_MINUTES : req.load_minutes[5:0];
        time_next.seconds = (req.load_seconds > {1'b0, cdt_pkg::MAX_SECONDS}) ?
                            cdt_pkg::MAX_SECONDS : req.load_seconds[5:0];
        time_next.hundredths = (req.load_hundredths > cdt_pkg::MAX_HUNDREDTHS) ?
                               cdt_pkg::MAX_HUNDREDTHS : req.load_hundredths;
      end
      cdt_pkg::OP_START: run_next = 1'b1;
      cdt_pkg::OP_STOP:  run_next = 1'b0;
      cdt_pkg::OP_FORCE: begin
        unique case (req.button)
          cdt_pkg::BTN_MINUTES:    time_next.minutes    = cdt_pkg::MAX_MINUTES;
          cdt_pkg::BTN_SECONDS:    time_next.seconds    = cdt_pkg::MAX_SECONDS;
          cdt_pkg::BTN_HUNDREDTHS: time_next.hundredths = cdt_pkg::MAX_HUNDREDTHS;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/cdt_seg.sv
`default_nettype none

module cdt_seg (
  input  wire cdt_pkg::time_t value,
  output logic [31:0]         segments_low,
  output logic [15:0]         segments_high
);

  logic [6:0] min_w;
  logic [6:0] sec_w;

  assign min_w = {1'b0, value.minutes};
  assign sec_w = {1'b0, value.seconds};

  // Split each field into digits and look up the segment bytes
  assign segments_low = {
    cdt_pkg::seg_of(cdt_pkg::tens_of(sec_w)),
    cdt_pkg::seg_of(cdt_pkg::ones_of(sec_w)),
    cdt_pkg::seg_of(cdt_pkg::tens_of(value.hundredths)),
    cdt_pkg::seg_of(cdt_pkg::ones_of(value.hundredths))
  };
  assign segments_high = {
    cdt_pkg::seg_of(cdt_pkg::tens_of(min_w)),
    cdt_pkg::seg_of(cdt_pkg::ones_of(min_w))
  };

endmodule

`default_nettype wire

### sv/countdown_timer_seven_segment_top.sv
// Countdown timer MM:SS:hh with six seven-segment digit codes.
// Input stream (s_*): one request per accepted beat. s_tuser carries the
// operation (tick, load, start, stop, force) and the force button; s_tdata
// carries the load values. Codes five to seven leave the state unchanged.
// Output stream (m_*): exactly one result per request, in order: time after
// the operation, running flag and the segment bytes of all six digits.
// A request accepted into the request register passes through the state
// update into the result register, which raises m_tvalid. Throughput is one
// request per cycle while the receiver does not stall; the state update is
// combinational logic between the request register and the result register.
// Reset (rst, synchronous): time 59:59:99, running, both stream stages empty.
// When the receiver stalls, the result register holds and the request
// register still takes one more request; after that s_tready drops until
// the result is taken. No result is lost or repeated.
`default_nettype none

module countdown_timer_seven_segment_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [6:0] load_minutes, [13:7] load_seconds, [20:14] load_hundredths, [23:21] zero
  input  wire logic [23:0] s_tdata,
  // [2:0] operation, [4:3] button
  input  wire logic [4:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [5:0] minutes_now, [11:6] seconds_now, [18:12] hundredths_now,
  // [19] is_running, [51:20] segments_low, [67:52] segments_high, [71:68] zero
  output logic [71:0]      m_tdata
);

  cdt_pkg::req_t  req;
  logic           req_valid;
  logic           advance;
  cdt_pkg::time_t time_next;
  logic           run_next;
  logic [31:0]    seg_low;
  logic [15:0]    seg_high;

  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.operation       <= s_tuser[2:0];
      req.button          <= s_tuser[4:3];
      req.load_minutes    <= s_tdata[6:0];
      req.load_seconds    <= s_tdata[13:7];
      req.load_hundredths <= s_tdata[20:14];
    end
  end

  cdt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .req       (req),
    .time_next (time_next),
    .run_next  (run_next)
  );

  cdt_seg u_seg (
    .value         (time_next),
    .segments_low  (seg_low),
    .segments_high (seg_high)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, seg_high, seg_low, run_next, time_next.hundredths,
                  time_next.seconds, time_next.minutes};
    end
  end

endmodule

`default_nettype wire

### sv/cdt_checker.sv
`default_nettype none
`include "countdown_timer_seven_segment_top_assert.svh"

module cdt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);

  logic [7:0] zero_seg;
  logic [5:0] mins;
  logic [5:0] secs;
  logic [6:0] hunds;
  logic       out_stall;
  logic       in_range;
  logic       zero_shown;

  assign zero_seg   = cdt_pkg::seg_of(4'd0);
  assign mins       = m_tdata[5:0];
  assign secs       = m_tdata[11:6];
  assign hunds      = m_tdata[18:12];
  assign out_stall  = m_tvalid && !m_tready;
  assign in_range   = (mins <= 6'd59) && (secs <= 6'd59) && (hunds <= 7'd99);
  assign zero_shown = (m_tdata[27:20] == zero_seg) && (m_tdata[35:28] == zero_seg);

  // A stalled result holds
  `CDT_ASSERT_NEXT(a_stall_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata))
  // Reported time stays in range
  `CDT_ASSERT_NOW(a_range, clk, rst, m_tvalid, in_range)
  // Zero hundredths show the zero pattern on both hundredths digits
  `CDT_ASSERT_NOW(a_seg_zero, clk, rst, m_tvalid && (hunds == 7'd0), zero_shown)
  // No result right after reset
  `CDT_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid)
  // Input is ready whenever the result stage is empty
  `CDT_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

endmodule

bind countdown_timer_seven_segment_top cdt_checker u_cdt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
